>>> design/ova_pkg.sv
// ----------------------------------------------------------------------------
// ova_pkg
// Shared widths, controller states and the command and status structures
// of the oldest-first voice allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ova_pkg;

    localparam int KEY_W              = 7;
    localparam int TIME_W             = 32;
    localparam int VOICE_W            = 5;
    localparam int CFG_W              = 6;
    localparam int MAX_VOICES_DEFAULT = 32;
    localparam int NUM_VOICES_RESET   = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_MATCH,
        ST_UP_FIND,
        ST_UP_LINK,
        ST_DN_READ,
        ST_DN_UPD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic match;
        logic up_find;
        logic up_link;
        logic dn_read;
        logic dn_upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic out_free;
    } status_t;

endpackage

>>> design/ova_req_if.sv
// ----------------------------------------------------------------------------
// ova_req_if
// Key event request channel with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ova_req_if;

    logic                       valid;
    logic                       ready;
    logic [ova_pkg::KEY_W-1:0]  key_number;
    logic                       key_up;
    logic [ova_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output key_number, output key_up, output time_us,
                    input ready);
    modport sink (input valid, input key_number, input key_up, input time_us,
                  output ready);

endinterface

>>> design/ova_rsp_if.sv
// ----------------------------------------------------------------------------
// ova_rsp_if
// Voice command result channel with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ova_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [ova_pkg::VOICE_W-1:0] voice_index;
    logic                        voice_start;
    logic [ova_pkg::KEY_W-1:0]   voice_key;
    logic                        was_stolen;
    logic [ova_pkg::TIME_W-1:0]  event_time;

    modport source (output valid, output voice_index, output voice_start,
                    output voice_key, output was_stolen, output event_time,
                    input ready);
    modport sink (input valid, input voice_index, input voice_start,
                  input voice_key, input was_stolen, input event_time,
                  output ready);

endinterface

>>> design/ova_ctrl.sv
// ----------------------------------------------------------------------------
// ova_ctrl
// Sequencer that steps one key event at a time through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ova_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_key_up,
    input  ova_pkg::status_t status,
    output logic             req_ready,
    output ova_pkg::cmd_t    cmd
);

    ova_pkg::state_t state_reg;
    ova_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ova_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ova_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = req_key_up ? ova_pkg::ST_UP_MATCH : ova_pkg::ST_DN_READ;
                end
            end
            ova_pkg::ST_UP_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ova_pkg::ST_UP_FIND;
            end
            ova_pkg::ST_UP_FIND:
            begin
                if (status.found)
                begin
                    cmd.up_find = 1'b1;
                    state_next  = ova_pkg::ST_UP_LINK;
                end
                else
                begin
                    state_next = ova_pkg::ST_IDLE;
                end
            end
            ova_pkg::ST_UP_LINK:
            begin
                cmd.up_link = 1'b1;
                state_next  = ova_pkg::ST_RESULT;
            end
            ova_pkg::ST_DN_READ:
            begin
                cmd.dn_read = 1'b1;
                state_next  = ova_pkg::ST_DN_UPD;
            end
            ova_pkg::ST_DN_UPD:
            begin
                cmd.dn_upd = 1'b1;
                state_next = ova_pkg::ST_RESULT;
            end
            ova_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ova_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ova_pkg::ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_req, cmd.match, cmd.up_find, cmd.up_link,
                  cmd.dn_read, cmd.dn_upd, cmd.load_out}))
        else $error("More than one datapath command in a cycle.");

endmodule

>>> design/ova_dp.sv
// ----------------------------------------------------------------------------
// ova_dp
// Voice state, key lanes, the assigned and released linked lists and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ova_dp #(
    parameter int MAX_VOICES = ova_pkg::MAX_VOICES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ova_pkg::cmd_t               cmd,
    output ova_pkg::status_t            status,
    input  logic [ova_pkg::KEY_W-1:0]   req_key_number,
    input  logic                        req_key_up,
    input  logic [ova_pkg::TIME_W-1:0]  req_time_us,
    input  logic                        cfg_wr_en,
    input  logic [ova_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    output logic [ova_pkg::VOICE_W-1:0] rsp_voice_index,
    output logic                        rsp_voice_start,
    output logic [ova_pkg::KEY_W-1:0]   rsp_voice_key,
    output logic                        rsp_was_stolen,
    output logic [ova_pkg::TIME_W-1:0]  rsp_event_time
);

    localparam int VW     = $clog2(MAX_VOICES);
    localparam int CW     = $clog2(MAX_VOICES + 1);
    localparam int NV_RST = (ova_pkg::NUM_VOICES_RESET > MAX_VOICES) ?
                            MAX_VOICES : ova_pkg::NUM_VOICES_RESET;

    function automatic logic [VW-1:0] vix(input logic [VW-1:0] x);
        vix = ({1'b0, x} < (VW + 1)'(MAX_VOICES)) ? x : '0;
    endfunction

    function automatic logic [VW-1:0] wrap_inc(input logic [VW-1:0] x);
        wrap_inc = (x == VW'(MAX_VOICES - 1)) ? '0 : x + VW'(1);
    endfunction

    // Control state.
    logic [CW-1:0]         num_reg,   num_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [VW-1:0]         ahead_reg, ahead_next;
    logic [VW-1:0]         atail_reg, atail_next;
    logic [VW-1:0]         rhead_reg, rhead_next;
    logic [VW-1:0]         rtail_reg, rtail_next;
    logic [MAX_VOICES-1:0] busy_reg,  busy_next;
    logic [MAX_VOICES-1:0] nir_valid_reg, nir_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // Request and working payload.
    logic [ova_pkg::KEY_W-1:0]  key_reg;
    logic                       up_reg;
    logic [ova_pkg::TIME_W-1:0] time_reg;
    logic [MAX_VOICES-1:0]      match_reg;
    logic [MAX_VOICES-1:0]      match_next;
    logic [VW-1:0]              v_reg;
    logic                       stolen_reg;
    logic [ova_pkg::KEY_W-1:0]  held_key_reg [MAX_VOICES];

    // Result register.
    logic [ova_pkg::VOICE_W-1:0] out_voice_reg;
    logic                        out_start_reg;
    logic [ova_pkg::KEY_W-1:0]   out_key_reg;
    logic                        out_stolen_reg;
    logic [ova_pkg::TIME_W-1:0]  out_time_reg;

    // Link memories.
    logic [VW-1:0] nia_mem [MAX_VOICES];
    logic [VW-1:0] pia_mem [MAX_VOICES];
    logic [VW-1:0] nir_mem [MAX_VOICES];
    logic [VW-1:0] nia_q, pia_q, nir_mem_q, nir_addr_q;
    logic          nir_vld_q;

    logic          nia_we, pia_we, nir_we, nia_re, pia_re, nir_re;
    logic [VW-1:0] nia_waddr, nia_wdata, pia_waddr, pia_wdata, nir_waddr, nir_wdata;
    logic [VW-1:0] nia_raddr, pia_raddr, nir_raddr;

    logic [CW-1:0]         cfg_num;
    logic [VW-1:0]         enc_v;
    logic [VW-1:0]         vcur;
    logic [VW-1:0]         link_n, link_p;
    logic [VW-1:0]         nir_eff;
    logic                  dn_steal;
    logic                  hk_we;
    logic                  v_load;
    logic [VW+ova_pkg::VOICE_W-1:0] v_wide;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_num = CW'(1);
        end
        else if (int'(cfg_wr_data) > MAX_VOICES)
        begin
            cfg_num = CW'(MAX_VOICES);
        end
        else
        begin
            cfg_num = CW'(cfg_wr_data);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            match_next[i] = busy_reg[i] && (held_key_reg[i] == key_reg) &&
                            (CW'(i) < num_reg);
        end
    end

    always_comb
    begin
        enc_v = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                enc_v = VW'(i);
            end
        end
    end

    assign status.found    = |match_reg;
    assign status.out_free = !out_valid_reg || rsp_ready;

    assign link_n   = vix(nia_q);
    assign link_p   = vix(pia_q);
    assign nir_eff  = nir_vld_q ? nir_mem_q : wrap_inc(nir_addr_q);
    assign dn_steal = !(count_reg < num_reg);
    assign v_wide   = {{ova_pkg::VOICE_W{1'b0}}, v_reg};

    always_comb
    begin
        num_next       = num_reg;
        count_next     = count_reg;
        ahead_next     = ahead_reg;
        atail_next     = atail_reg;
        rhead_next     = rhead_reg;
        rtail_next     = rtail_reg;
        busy_next      = busy_reg;
        nir_valid_next = nir_valid_reg;
        out_valid_next = out_valid_reg;
        nia_we = 1'b0;  nia_waddr = '0;  nia_wdata = '0;
        pia_we = 1'b0;  pia_waddr = '0;  pia_wdata = '0;
        nir_we = 1'b0;  nir_waddr = '0;  nir_wdata = '0;
        nia_re = 1'b0;  nia_raddr = '0;
        pia_re = 1'b0;  pia_raddr = '0;
        nir_re = 1'b0;  nir_raddr = '0;
        vcur   = '0;
        v_load = 1'b0;
        hk_we  = 1'b0;

        if (cfg_wr_en)
        begin
            num_next       = cfg_num;
            count_next     = '0;
            ahead_next     = '0;
            atail_next     = '0;
            rhead_next     = '0;
            rtail_next     = VW'(cfg_num - CW'(1));
            busy_next      = '0;
            nir_valid_next = '0;
        end
        else if (cmd.up_find)
        begin
            // The released voice joins the tail of the released order.
            vcur      = enc_v;
            v_load    = 1'b1;
            nir_we    = 1'b1;
            nir_waddr = vix(rtail_reg);
            nir_wdata = enc_v;
            nir_valid_next[vix(rtail_reg)] = 1'b1;
            rtail_next = enc_v;
            if (count_reg >= num_reg)
            begin
                rhead_next = enc_v;
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - CW'(1);
            end
            nia_re    = 1'b1;
            nia_raddr = enc_v;
            pia_re    = 1'b1;
            pia_raddr = enc_v;
        end
        else if (cmd.up_link)
        begin
            if (ahead_reg == v_reg)
            begin
                ahead_next = link_n;
            end
            else if (atail_reg == v_reg)
            begin
                atail_next = link_p;
            end
            else
            begin
                nia_we    = 1'b1;
                nia_waddr = link_p;
                nia_wdata = link_n;
                pia_we    = 1'b1;
                pia_waddr = link_n;
                pia_wdata = link_p;
            end
            busy_next[v_reg] = 1'b0;
        end
        else if (cmd.dn_read)
        begin
            v_load = 1'b1;
            if (!dn_steal)
            begin
                vcur = vix(rhead_reg);
                if (count_reg == '0)
                begin
                    ahead_next = vcur;
                    atail_next = vcur;
                end
                nir_re     = 1'b1;
                nir_raddr  = vcur;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                vcur      = vix(ahead_reg);
                nia_re    = 1'b1;
                nia_raddr = vcur;
            end
        end
        else if (cmd.dn_upd)
        begin
            if (!stolen_reg)
            begin
                rhead_next = vix(nir_eff);
            end
            else
            begin
                ahead_next = link_n;
            end
            nia_we    = 1'b1;
            nia_waddr = vix(atail_reg);
            nia_wdata = v_reg;
            pia_we    = 1'b1;
            pia_waddr = v_reg;
            pia_wdata = vix(atail_reg);
            atail_next = v_reg;
            hk_we      = 1'b1;
            busy_next[v_reg] = 1'b1;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg       <= CW'(NV_RST);
            count_reg     <= '0;
            ahead_reg     <= '0;
            atail_reg     <= '0;
            rhead_reg     <= '0;
            rtail_reg     <= VW'(NV_RST - 1);
            busy_reg      <= '0;
            nir_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            num_reg       <= num_next;
            count_reg     <= count_next;
            ahead_reg     <= ahead_next;
            atail_reg     <= atail_next;
            rhead_reg     <= rhead_next;
            rtail_reg     <= rtail_next;
            busy_reg      <= busy_next;
            nir_valid_reg <= nir_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg    <= req_key_number;
            up_reg     <= req_key_up;
            time_reg   <= req_time_us;
            stolen_reg <= 1'b0;
        end
        else if (cmd.dn_read)
        begin
            stolen_reg <= dn_steal;
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
        if (v_load)
        begin
            v_reg <= vcur;
        end
        if (hk_we)
        begin
            held_key_reg[v_reg] <= key_reg;
        end
        if (cmd.load_out)
        begin
            out_voice_reg  <= v_wide[ova_pkg::VOICE_W-1:0];
            out_start_reg  <= !up_reg;
            out_key_reg    <= key_reg;
            out_stolen_reg <= stolen_reg && !up_reg;
            out_time_reg   <= time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nia_we)
        begin
            nia_mem[nia_waddr] <= nia_wdata;
        end
        if (nia_re)
        begin
            nia_q <= nia_mem[nia_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pia_we)
        begin
            pia_mem[pia_waddr] <= pia_wdata;
        end
        if (pia_re)
        begin
            pia_q <= pia_mem[pia_raddr];
        end
    end

    // An entry never written since the last reinitialisation reads as its
    // successor index.
    always_ff @(posedge clk)
    begin
        if (nir_we)
        begin
            nir_mem[nir_waddr] <= nir_wdata;
        end
        if (nir_re)
        begin
            nir_mem_q  <= nir_mem[nir_raddr];
            nir_vld_q  <= nir_valid_reg[nir_raddr];
            nir_addr_q <= nir_raddr;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_voice_index = out_voice_reg;
    assign rsp_voice_start = out_start_reg;
    assign rsp_voice_key   = out_key_reg;
    assign rsp_was_stolen  = out_stolen_reg;
    assign rsp_event_time  = out_time_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= num_reg)
        else $error("Assigned voice count exceeds the voice count.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dn_upd |=> busy_reg[v_reg])
        else $error("Started voice is not marked busy.");

    a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.up_link |=> !busy_reg[v_reg])
        else $error("Released voice is still marked busy.");

    a_steal_is_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_was_stolen |-> rsp_voice_start)
        else $error("A release result is flagged as stolen.");

endmodule

>>> design/oldest_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// oldest_voice_allocator_core
// A key-down passes the read and update states, a matched key-up the match,
// find and link states; both then load the result once the output is free.
// An unmatched key-up ends after the find state with no result. One request
// runs at a time, set by the sequencer's list updates via the link memories.
// Async reset: 32 voices (at most MAX_VOICES), all released; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oldest_voice_allocator_core #(
    parameter int MAX_VOICES = ova_pkg::MAX_VOICES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    ova_req_if.sink                   req,
    ova_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [ova_pkg::CFG_W-1:0] cfg_wr_data
);

    ova_pkg::cmd_t    cmd;
    ova_pkg::status_t status;

    ova_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_key_up (req.key_up),
        .status     (status),
        .req_ready  (req.ready),
        .cmd        (cmd)
    );

    ova_dp #(
        .MAX_VOICES (MAX_VOICES)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_key_number  (req.key_number),
        .req_key_up      (req.key_up),
        .req_time_us     (req.time_us),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_voice_index (rsp.voice_index),
        .rsp_voice_start (rsp.voice_start),
        .rsp_voice_key   (rsp.voice_key),
        .rsp_was_stolen  (rsp.was_stolen),
        .rsp_event_time  (rsp.event_time)
    );

endmodule
